>>> hw/rtl/ksrpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key state and recent press buffer: shared types
// Request and result payloads, action codes and the controller command group.
// ----------------------------------------------------------------------------
package ksrpb_pkg;

	typedef enum logic [2:0] {
		ACT_EVENT   = 3'd0,
		ACT_QUERY   = 3'd1,
		ACT_POP     = 3'd2,
		ACT_CLEAR   = 3'd3,
		ACT_RELEASE = 3'd4
	} action_t;

	localparam int unsigned KEY_W = 8;

	typedef struct packed {
		logic [2:0]       action;
		logic [KEY_W-1:0] key_code;
		logic             key_down;
	} req_t;

	typedef struct packed {
		logic             held;
		logic             in_history;
		logic [KEY_W-1:0] popped_key;
		logic             popped_valid;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic execute;
	} ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/ksrpb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key state and recent press buffer: controller
// Steps each request through capture, lookup and execute.
// ----------------------------------------------------------------------------
module ksrpb_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	output logic               done,
	output ksrpb_pkg::ctrl_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.lookup  = (state_q == ST_LOOK);
		cmd.execute = (state_q == ST_EXEC);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

>>> hw/rtl/ksrpb_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key state and recent press buffer: datapath
// Held-bit memory with per-key valid bits, circular press history, result.
// ----------------------------------------------------------------------------
module ksrpb_dpath #(
	parameter int unsigned KEY_COUNT     = 256,
	parameter int unsigned HISTORY_DEPTH = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  ksrpb_pkg::ctrl_t   cmd,
	input  ksrpb_pkg::req_t    req,
	output ksrpb_pkg::rsp_t    rsp
);

	localparam int unsigned KW  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int unsigned KIW = ((KW > ksrpb_pkg::KEY_W) ? KW : ksrpb_pkg::KEY_W) + 1;
	localparam int unsigned SW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CW  = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned DW  = CW + 1;

	ksrpb_pkg::req_t            req_q;
	ksrpb_pkg::rsp_t            rsp_q;
	ksrpb_pkg::rsp_t            rsp_n;

	logic                       held_mem [KEY_COUNT];
	logic [KEY_COUNT-1:0]       held_vld_q;
	logic [ksrpb_pkg::KEY_W-1:0] hist_q [HISTORY_DEPTH];
	logic [CW-1:0]              count_q;
	logic [SW-1:0]              newest_q;

	logic                       held_rd_s1;
	logic                       held_vld_s1;
	logic                       match_s1;
	logic [ksrpb_pkg::KEY_W-1:0] oldest_s1;

	logic [KIW-1:0]             key_ext;
	logic [KW-1:0]              key_idx;
	logic                       key_in_range;
	logic [HISTORY_DEPTH-1:0]   match_vec;
	logic [DW-1:0]              oldest_full;
	logic [SW-1:0]              oldest_slot;
	logic [SW-1:0]              newest_next;
	logic                       cur_held;
	logic                       do_write;
	logic                       do_push;

	assign key_ext      = KIW'(req_q.key_code);
	assign key_idx      = key_ext[KW-1:0];
	assign key_in_range = key_ext < KIW'(KEY_COUNT);
	assign cur_held     = held_vld_s1 & held_rd_s1;
	assign newest_next  = (newest_q == SW'(HISTORY_DEPTH - 1)) ? '0 : newest_q + 1'b1;

	// Oldest slot is newest minus (count - 1), modulo the depth.
	always_comb begin
		oldest_full = DW'(newest_q) + DW'(HISTORY_DEPTH) + DW'(1) - DW'(count_q);
		if (oldest_full >= DW'(HISTORY_DEPTH)) begin
			oldest_full = oldest_full - DW'(HISTORY_DEPTH);
		end
		oldest_slot = oldest_full[SW-1:0];
	end

	// Compare every slot in parallel; a slot counts only while it is live.
	always_comb begin : cmp_blk
		logic [DW-1:0] age;
		age = '0;
		for (int s = 0; s < HISTORY_DEPTH; s++) begin
			age = DW'(newest_q) + DW'(HISTORY_DEPTH) - DW'(s);
			if (age >= DW'(HISTORY_DEPTH)) begin
				age = age - DW'(HISTORY_DEPTH);
			end
			match_vec[s] = (age < DW'(count_q)) && (hist_q[s] == req_q.key_code);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.lookup) begin
			held_rd_s1  <= held_mem[key_idx];
			held_vld_s1 <= held_vld_q[key_idx];
			match_s1    <= |match_vec;
			oldest_s1   <= hist_q[oldest_slot];
		end
		if (cmd.execute) begin
			rsp_q <= rsp_n;
		end
		if (do_write) begin
			held_mem[key_idx] <= req_q.key_down;
		end
		if (do_push) begin
			hist_q[newest_next] <= req_q.key_code;
		end
	end

	always_comb begin
		rsp_n    = '0;
		do_write = 1'b0;
		do_push  = 1'b0;
		case (ksrpb_pkg::action_t'(req_q.action))
			ksrpb_pkg::ACT_EVENT: begin
				do_write = cmd.execute && key_in_range && (cur_held != req_q.key_down);
				do_push  = do_write && req_q.key_down;
			end
			ksrpb_pkg::ACT_QUERY: begin
				rsp_n.held       = key_in_range && cur_held;
				rsp_n.in_history = match_s1;
			end
			ksrpb_pkg::ACT_POP: begin
				if (count_q != '0) begin
					rsp_n.popped_key   = oldest_s1;
					rsp_n.popped_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= '0;
			count_q    <= '0;
			newest_q   <= '0;
		end else if (cmd.execute) begin
			if (do_write) begin
				held_vld_q[key_idx] <= 1'b1;
			end
			if (do_push) begin
				newest_q <= newest_next;
				if (count_q != CW'(HISTORY_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (req_q.action == ksrpb_pkg::ACT_POP && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
			if (req_q.action == ksrpb_pkg::ACT_CLEAR) begin
				count_q <= '0;
			end
			if (req_q.action == ksrpb_pkg::ACT_RELEASE) begin
				held_vld_q <= '0;
			end
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HISTORY_DEPTH))
		else $error("history count above depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && req_q.action == ksrpb_pkg::ACT_POP && count_q != '0)
		|=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not drop one entry");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && req_q.action != ksrpb_pkg::ACT_POP)
		|=> (!rsp_q.popped_valid && rsp_q.popped_key == '0))
		else $error("pop fields set by a non-pop request");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && req_q.action == ksrpb_pkg::ACT_RELEASE) |=> (held_vld_q == '0))
		else $error("release all left a key held");

endmodule
`default_nettype wire

>>> hw/rtl/key_state_and_recent_press_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key state and recent press buffer
// Held/released bit per key plus a circular history of recent presses.
// ----------------------------------------------------------------------------
//  channel   ports              handshake
//  request   start, req         taken at a clock edge with start high, busy low
//  result    done, rsp          one cycle on done, no back pressure
//
//  Each request passes from acceptance to done through capture, then the
//  registered read of the held-bit memory and the parallel history compare,
//  then execute, which updates state and registers the result.
//  busy drops in the cycle done is high, so a new request may start then.
//  Reset clears all held bits (per-key valid bits) and empties the history.
//  The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module key_state_and_recent_press_buffer #(
	parameter int unsigned KEY_COUNT     = 256,
	parameter int unsigned HISTORY_DEPTH = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  ksrpb_pkg::req_t   req,
	output logic              busy,
	output logic              done,
	output ksrpb_pkg::rsp_t   rsp
);

	// Command group from the controller to the datapath.
	ksrpb_pkg::ctrl_t cmd;

	// Sequence the request: capture, look up, execute.
	ksrpb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Hold the key bits and press history; drop the oldest press when full.
	ksrpb_dpath #(
		.KEY_COUNT     (KEY_COUNT),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

>>> tb/tb_key_state_and_recent_press_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key state and recent press buffer testbench
// Drives key events, queries, pops, history clears and release-all requests
// through the start/busy handshake, predicts each result from a local copy of
// the held bits and the press history, and checks every done strobe in order.
// ----------------------------------------------------------------------------
module tb_key_state_and_recent_press_buffer;

	localparam int unsigned KEYS       = 256;
	localparam int unsigned LOG_DEPTH  = 32;
	localparam int unsigned STALL_LIMIT = 4096;

	logic clk;
	logic arst_n;
	logic start;
	ksrpb_pkg::req_t req;
	logic busy;
	logic done;
	ksrpb_pkg::rsp_t rsp;

	key_state_and_recent_press_buffer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	// Local copy of the block state: one held bit per key, circular press log.
	bit         key_pressed [KEYS];
	logic [7:0] press_log [LOG_DEPTH];
	int         log_count  = 0;
	int         log_newest = 0;

	ksrpb_pkg::rsp_t pending_rsp[$];
	ksrpb_pkg::rsp_t oldest_rsp;
	int   mismatch_count = 0;
	int   stall_cycles   = 0;
	bit   idle_enabled   = 1'b1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Scan the live log entries from newest to oldest for a key.
	function automatic bit key_in_log(input logic [7:0] key);
		int slot;
		slot = log_newest;
		for (int i = 0; i < log_count; i++) begin
			if (press_log[slot] == key)
				return 1'b1;
			slot = (slot + LOG_DEPTH - 1) % LOG_DEPTH;
		end
		return 1'b0;
	endfunction

	// Apply one accepted request to the local state and return its result.
	function automatic ksrpb_pkg::rsp_t apply_request(input ksrpb_pkg::req_t r);
		ksrpb_pkg::rsp_t res;
		int   oldest;
		res = '0;
		case (r.action)
			ksrpb_pkg::ACT_EVENT: begin
				// Act only on a level change; a new press goes to the log,
				// overwriting the oldest entry once the log is full.
				if (r.key_code < KEYS && key_pressed[r.key_code] != r.key_down) begin
					key_pressed[r.key_code] = r.key_down;
					if (r.key_down) begin
						log_newest = (log_newest + 1) % LOG_DEPTH;
						press_log[log_newest] = r.key_code;
						if (log_count < LOG_DEPTH)
							log_count++;
					end
				end
			end
			ksrpb_pkg::ACT_QUERY: begin
				if (r.key_code < KEYS)
					res.held = key_pressed[r.key_code];
				res.in_history = key_in_log(r.key_code);
			end
			ksrpb_pkg::ACT_POP: begin
				// Leave the state alone on an empty log and answer zero.
				if (log_count > 0) begin
					oldest = (log_newest + LOG_DEPTH + 1 - log_count) % LOG_DEPTH;
					res.popped_key   = press_log[oldest];
					res.popped_valid = 1'b1;
					log_count--;
				end
			end
			ksrpb_pkg::ACT_CLEAR: log_count = 0;
			ksrpb_pkg::ACT_RELEASE: begin
				foreach (key_pressed[k])
					key_pressed[k] = 1'b0;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic ksrpb_pkg::req_t make_req(input logic [2:0] act,
			input logic [7:0] key, input logic down);
		ksrpb_pkg::req_t r;
		r.action   = act;
		r.key_code = key;
		r.key_down = down;
		return r;
	endfunction

	// Random request: mostly key events on a small key pool so the log fills,
	// wraps and gets query hits; a few full-range keys and unused actions.
	function automatic ksrpb_pkg::req_t random_req();
		ksrpb_pkg::req_t r;
		int   pick;
		pick = $urandom_range(99);
		r.key_code = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(23));
		r.key_down = ($urandom_range(99) < 60);
		if (pick < 55)
			r.action = ksrpb_pkg::ACT_EVENT;
		else if (pick < 75)
			r.action = ksrpb_pkg::ACT_QUERY;
		else if (pick < 87)
			r.action = ksrpb_pkg::ACT_POP;
		else if (pick < 91)
			r.action = ksrpb_pkg::ACT_CLEAR;
		else if (pick < 95)
			r.action = ksrpb_pkg::ACT_RELEASE;
		else
			r.action = 3'($urandom_range(7));
		return r;
	endfunction

	// Send one request: idle for a random gap, then hold start high until the
	// block takes it. Leave start high so back-to-back requests stream.
	task automatic send_request(input ksrpb_pkg::req_t r);
		while (idle_enabled && $urandom_range(99) < 30) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy);
		pending_rsp.push_back(apply_request(r));
	endtask

	// Drop start and hold until every predicted result has come back.
	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of the key field, repeated levels, pops on an empty log,
	// clear keeping held bits, release-all keeping the log, unused actions.
	task automatic test_directed_cases();
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_EVENT, 8'd0, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_EVENT, 8'd255, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_EVENT, 8'd0, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd255, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd7, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_POP, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_EVENT, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_EVENT, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_POP, 8'd255, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_POP, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_EVENT, 8'd5, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_CLEAR, 8'd5, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd5, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_POP, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_EVENT, 8'd170, 1'b1));
		send_request(make_req(ksrpb_pkg::ACT_RELEASE, 8'd0, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd5, 1'b0));
		send_request(make_req(ksrpb_pkg::ACT_QUERY, 8'd170, 1'b1));
		send_request(make_req(3'd5, 8'd85, 1'b1));
		send_request(make_req(3'd6, 8'd255, 1'b0));
		send_request(make_req(3'd7, 8'd0, 1'b1));
	endtask

	task automatic test_random_traffic(input int count, input bit with_idle);
		idle_enabled = with_idle;
		repeat (count)
			send_request(random_req());
		idle_enabled = 1'b1;
	endtask

	// Press more distinct keys than the log holds so it wraps and drops its
	// oldest entries, with queries across the pressed range and a few pops.
	task automatic test_log_overflow();
		logic [7:0] base;
		base = 8'($urandom_range(216));
		send_request(make_req(ksrpb_pkg::ACT_RELEASE, 8'($urandom_range(255)),
			1'($urandom_range(1))));
		for (int i = 0; i < 40; i++) begin
			send_request(make_req(ksrpb_pkg::ACT_EVENT, base + 8'(i), 1'b1));
			if (i % 4 == 3)
				send_request(make_req(ksrpb_pkg::ACT_QUERY,
					base + 8'($urandom_range(39)), 1'b0));
		end
		for (int i = 0; i < 10; i++)
			send_request(make_req(ksrpb_pkg::ACT_QUERY, base + 8'(i), 1'b0));
		repeat (6)
			send_request(make_req(ksrpb_pkg::ACT_POP, 8'($urandom_range(255)), 1'b0));
	endtask

	// Let the block drain completely between two bursts.
	task automatic test_drain_pause();
		test_random_traffic(20, 1'b1);
		wait_for_results();
		test_random_traffic(20, 1'b1);
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(200, 1'b1);
		test_log_overflow();
		test_drain_pause();
		test_random_traffic(150, 1'b0);
		test_log_overflow();
		test_random_traffic(100, 1'b1);

		wait_for_results();
		repeat (8)
			@(posedge clk);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Check each done strobe against the oldest predicted result.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result with no request outstanding: %p", rsp);
				mismatch_count++;
			end else begin
				oldest_rsp = pending_rsp.pop_front();
				if (rsp.held !== oldest_rsp.held) begin
					$error("held: expected %0b, got %0b", oldest_rsp.held, rsp.held);
					mismatch_count++;
				end
				if (rsp.in_history !== oldest_rsp.in_history) begin
					$error("in_history: expected %0b, got %0b",
						oldest_rsp.in_history, rsp.in_history);
					mismatch_count++;
				end
				if (rsp.popped_key !== oldest_rsp.popped_key) begin
					$error("popped_key: expected %0d, got %0d",
						oldest_rsp.popped_key, rsp.popped_key);
					mismatch_count++;
				end
				if (rsp.popped_valid !== oldest_rsp.popped_valid) begin
					$error("popped_valid: expected %0b, got %0b",
						oldest_rsp.popped_valid, rsp.popped_valid);
					mismatch_count++;
				end
			end
		end
	end

	// Stop the run if neither a request nor a result moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
